/* hw/rtl/ordered_list_insert_delete_macros.svh */
// Assertion helpers included by the top-level RTL module.
`ifndef ORDERED_LIST_INSERT_DELETE_MACROS_SVH
`define ORDERED_LIST_INSERT_DELETE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define OLI_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define OLI_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/oli_pkg.sv */
`default_nettype none

package oli_pkg;

    localparam int DEFAULT_LIST_DEPTH = 16;

    localparam int CMD_W    = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 8;
    localparam int STATUS_W = 2;
    // position/count width in the control interface, covers depth up to 256
    localparam int AT_W     = POS_W + 1;

    localparam logic [CMD_W-1:0] CMD_ADD_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ADD_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ADD_POS   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DEL_FRONT = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DEL_BACK  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_DEL_POS   = 3'd5;

    localparam logic [STATUS_W-1:0] STAT_DONE = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NONE = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic                load;   // capture input value
        logic                exec;   // execute, load output register
        logic                ins;    // open a gap at 'at'
        logic                del;    // close the gap at 'at'
        logic [AT_W-1:0]     at;     // slot index
        logic [STATUS_W-1:0] status;
    } oli_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [AT_W-1:0] count;
    } oli_stat_t;

endpackage

`default_nettype wire

/* hw/rtl/oli_ctrl.sv */
`default_nettype none

module oli_ctrl import oli_pkg::*; #(
    parameter int LIST_DEPTH = DEFAULT_LIST_DEPTH
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [CMD_W-1:0] s_cmd,
    input  wire logic [POS_W-1:0] s_pos,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    input  wire oli_stat_t        stat,
    output oli_cmd_t              cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic             state_reg, state_next;
    logic             m_valid_reg, m_valid_next;
    logic [CMD_W-1:0] cmd_reg;
    logic [POS_W-1:0] pos_reg;

    logic                accept;
    logic                exec_go;
    logic [AT_W-1:0]     cnt;
    logic [AT_W-1:0]     idx;
    logic                full;
    logic                ins_ok;
    logic                del_ok;
    logic [AT_W-1:0]     at;
    logic [STATUS_W-1:0] status;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign exec_go  = (state_reg == ST_EXEC) && (!m_valid_reg || m_tready);
    assign m_tvalid = m_valid_reg;

    assign cnt  = stat.count;
    assign full = (cnt == AT_W'(LIST_DEPTH));
    // 1-based position to slot; 0 and 1 both mean front
    assign idx  = (pos_reg <= POS_W'(1)) ? '0 : (AT_W'(pos_reg) - AT_W'(1));

    always_comb begin
        ins_ok = 1'b0;
        del_ok = 1'b0;
        at     = '0;
        case (cmd_reg)
            CMD_ADD_FRONT: begin
                ins_ok = !full;
                at     = '0;
            end
            CMD_ADD_BACK: begin
                ins_ok = !full;
                at     = cnt;
            end
            CMD_ADD_POS: begin
                ins_ok = !full;
                at     = (idx > cnt) ? cnt : idx;   // past the end appends
            end
            CMD_DEL_FRONT: begin
                del_ok = (cnt != '0);
                at     = '0;
            end
            CMD_DEL_BACK: begin
                del_ok = (cnt != '0);
                at     = cnt - AT_W'(1);
            end
            CMD_DEL_POS: begin
                del_ok = (idx < cnt);
                at     = idx;
            end
            default: begin
                ins_ok = 1'b0;
                del_ok = 1'b0;
            end
        endcase
    end

    always_comb begin
        status = STAT_DONE;
        if ((cmd_reg == CMD_ADD_FRONT || cmd_reg == CMD_ADD_BACK ||
             cmd_reg == CMD_ADD_POS) && full) begin
            status = STAT_FULL;
        end else if ((cmd_reg == CMD_DEL_FRONT || cmd_reg == CMD_DEL_BACK ||
                      cmd_reg == CMD_DEL_POS) && !del_ok) begin
            status = STAT_NONE;
        end
    end

    assign cmd.load   = accept;
    assign cmd.exec   = exec_go;
    assign cmd.ins    = exec_go && ins_ok;
    assign cmd.del    = exec_go && del_ok;
    assign cmd.at     = at;
    assign cmd.status = status;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        if (m_tready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (exec_go) begin
                    state_next   = ST_IDLE;
                    m_valid_next = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg <= s_cmd;
            pos_reg <= s_pos;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/oli_datapath.sv */
`default_nettype none

module oli_datapath import oli_pkg::*; #(
    parameter int LIST_DEPTH = DEFAULT_LIST_DEPTH,
    parameter int CNT_W      = $clog2(LIST_DEPTH + 1)
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire oli_cmd_t                  cmd,
    input  wire logic signed [VALUE_W-1:0] s_value,
    output oli_stat_t                      stat,
    output logic [STATUS_W-1:0]            out_status,
    output logic signed [VALUE_W-1:0]      out_removed,
    output logic [CNT_W-1:0]               out_count
);

    localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

    logic signed [VALUE_W-1:0] entries_reg [LIST_DEPTH];
    logic signed [VALUE_W-1:0] value_reg;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [IDX_W-1:0]          at_i;
    logic [STATUS_W-1:0]       status_reg;
    logic signed [VALUE_W-1:0] removed_reg;
    logic [CNT_W-1:0]          count_out_reg;

    assign at_i       = cmd.at[IDX_W-1:0];
    assign stat.count = AT_W'(count_reg);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            value_reg <= s_value;
        end
    end

    // slots past 'at' move back on insert; from 'at' on, forward on delete
    genvar k;
    generate
        for (k = 0; k < LIST_DEPTH; k++) begin : g_slot
            localparam logic [AT_W-1:0] KI = AT_W'(k);
            logic signed [VALUE_W-1:0] prev_w;
            logic signed [VALUE_W-1:0] nxt_w;

            if (k == 0) begin : g_first
                assign prev_w = value_reg;
            end else begin : g_mid
                assign prev_w = entries_reg[k-1];
            end

            if (k == LIST_DEPTH - 1) begin : g_last
                assign nxt_w = entries_reg[k];
            end else begin : g_inner
                assign nxt_w = entries_reg[k+1];
            end

            always_ff @(posedge aclk) begin
                if (cmd.ins) begin
                    if (KI > cmd.at) begin
                        entries_reg[k] <= prev_w;
                    end else if (KI == cmd.at) begin
                        entries_reg[k] <= value_reg;
                    end
                end else if (cmd.del && (KI >= cmd.at)) begin
                    entries_reg[k] <= nxt_w;
                end
            end
        end
    endgenerate

    always_comb begin
        count_next = count_reg;
        if (cmd.ins) begin
            count_next = count_reg + CNT_W'(1);
        end else if (cmd.del) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            status_reg    <= cmd.status;
            removed_reg   <= cmd.del ? entries_reg[at_i] : '0;
            count_out_reg <= count_next;
        end
    end

    assign out_status  = status_reg;
    assign out_removed = removed_reg;
    assign out_count   = count_out_reg;

endmodule

`default_nettype wire

/* hw/rtl/ordered_list_insert_delete.sv */
// Ordered list of signed 32-bit values, LIST_DEPTH entries deep, slot 0 at
// the front. Each input transaction carries a command (add front, add back,
// add at a 1-based position, delete front, delete back, delete at position);
// each produces exactly one result transaction with a status (done, list
// full, nothing to delete there), the removed value (zero unless a delete
// succeeded) and the entry count after the command. Positions 0 and 1 both
// mean the front; an insert past the end appends, a delete past the end
// fails. Unused command codes change nothing and report done. Entries live
// in a register bank that shifts every slot behind the target in parallel,
// so a command is first captured, then updates the bank and loads the result
// register in the execute state. A new command is accepted only after the
// previous one has updated the bank; a result still waiting on the output
// register holds the update but not the capture of the next command.
// No clearing pass after reset: the count starts at zero.
`default_nettype none

module ordered_list_insert_delete import oli_pkg::*; #(
    parameter int  LIST_DEPTH = DEFAULT_LIST_DEPTH,
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1),
    localparam int S_RAW_W    = CMD_W + VALUE_W + POS_W,
    localparam int S_TDATA_W  = ((S_RAW_W + 7) / 8) * 8,
    localparam int M_RAW_W    = STATUS_W + VALUE_W + CNT_W,
    localparam int M_TDATA_W  = ((M_RAW_W + 7) / 8) * 8
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // command transactions
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,  // cmd[2:0], value[34:3], pos[42:35]
    // result transactions
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata   // status, removed_value, count
);

    logic [CMD_W-1:0]          s_cmd;
    logic signed [VALUE_W-1:0] s_value;
    logic [POS_W-1:0]          s_pos;

    oli_cmd_t  cmd;
    oli_stat_t stat;

    logic [STATUS_W-1:0]       out_status;
    logic signed [VALUE_W-1:0] out_removed;
    logic [CNT_W-1:0]          out_count;

    // unpack the command transaction
    assign s_cmd   = s_tdata[CMD_W-1:0];
    assign s_value = s_tdata[CMD_W+VALUE_W-1:CMD_W];
    assign s_pos   = s_tdata[S_RAW_W-1:CMD_W+VALUE_W];

    oli_ctrl #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_cmd    (s_cmd),
        .s_pos    (s_pos),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    oli_datapath #(
        .LIST_DEPTH (LIST_DEPTH),
        .CNT_W      (CNT_W)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .s_value     (s_value),
        .stat        (stat),
        .out_status  (out_status),
        .out_removed (out_removed),
        .out_count   (out_count)
    );

    // status lowest, then removed value, then count; zero padded to bytes
    assign m_tdata = M_TDATA_W'({out_count, out_removed, out_status});

`include "ordered_list_insert_delete_macros.svh"

    `OLI_ASSERT_IMPL(a_count_bound, aclk, aresetn, m_tvalid,
        out_count <= CNT_W'(LIST_DEPTH), "count above list depth")
    `OLI_ASSERT_IMPL(a_full_count, aclk, aresetn, m_tvalid && (out_status == STAT_FULL),
        out_count == CNT_W'(LIST_DEPTH), "full status with room left")
    `OLI_ASSERT_IMPL(a_fail_zero, aclk, aresetn, m_tvalid && (out_status != STAT_DONE),
        out_removed == '0, "failed command returned a value")
    `OLI_ASSERT_NEXT(a_one_inflight, aclk, aresetn, s_tvalid && s_tready,
        !s_tready, "second command taken during update")

endmodule

`default_nettype wire

/* sim/testbench.sv */
`default_nettype none

// Checks the ordered list block command by command. Every accepted command
// transaction runs through a mirror of the list kept here, and the predicted
// result (or its row's typed result) waits in a queue for the matching result.
module testbench;
    import oli_pkg::*;

    localparam int LIST_DEPTH  = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RAND_CMDS   = 1270;

    // command codes the block leaves unused: no change, done, count reported
    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

    localparam logic [CMD_W-1:0] ADD_CODES [3] = '{CMD_ADD_FRONT, CMD_ADD_BACK, CMD_ADD_POS};
    localparam logic [CMD_W-1:0] DEL_CODES [3] = '{CMD_DEL_FRONT, CMD_DEL_BACK, CMD_DEL_POS};

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  removed;
        logic [4:0]          count;
    } list_result_t;

    // One directed row: the command, how often to repeat it, whether to
    // draw a fresh random value each time, and an optional typed result.
    typedef struct packed {
        logic [CMD_W-1:0]   op;
        logic [VALUE_W-1:0] value;
        logic [POS_W-1:0]   pos;
        logic [4:0]         reps;
        logic               fresh;
        logic               known;
        list_result_t       want;
    } cmd_row_t;

    localparam int DIR_ROWS = 21;

    // list contents noted in comments above some rows
    localparam cmd_row_t DIR_TABLE [DIR_ROWS] = '{
        '{CMD_DEL_FRONT, 32'h0,         8'd0,   5'd1,  1'b0, 1'b1, '{STAT_NONE, 32'h0, 5'd0}},
        '{CMD_DEL_POS,   32'h0,         8'd0,   5'd1,  1'b0, 1'b1, '{STAT_NONE, 32'h0, 5'd0}},
        // positional insert on an empty list, far past the end
        '{CMD_ADD_POS,   32'h7FFFFFFF,  8'd200, 5'd1,  1'b0, 1'b1, '{STAT_DONE, 32'h0, 5'd1}},
        '{CMD_ADD_FRONT, 32'h80000000,  8'd0,   5'd1,  1'b0, 1'b1, '{STAT_DONE, 32'h0, 5'd2}},
        '{CMD_ADD_BACK,  32'hFFFFFFFF,  8'd0,   5'd1,  1'b0, 1'b1, '{STAT_DONE, 32'h0, 5'd3}},
        // pos 0 and pos 1 both land at the front
        '{CMD_ADD_POS,   32'd5,         8'd0,   5'd1,  1'b0, 1'b1, '{STAT_DONE, 32'h0, 5'd4}},
        '{CMD_ADD_POS,   32'd6,         8'd1,   5'd1,  1'b0, 1'b1, '{STAT_DONE, 32'h0, 5'd5}},
        // 6 5 min max -1, then append via pos 255
        '{CMD_ADD_POS,   32'h0,         8'd255, 5'd1,  1'b0, 1'b1, '{STAT_DONE, 32'h0, 5'd6}},
        '{CMD_DEL_POS,   32'h0,         8'd255, 5'd1,  1'b0, 1'b1, '{STAT_NONE, 32'h0, 5'd6}},
        '{CMD_DEL_POS,   32'h0,         8'd7,   5'd1,  1'b0, 1'b1, '{STAT_NONE, 32'h0, 5'd6}},
        '{CMD_SPARE_LO,  32'h12345678,  8'd3,   5'd1,  1'b0, 1'b1, '{STAT_DONE, 32'h0, 5'd6}},
        '{CMD_SPARE_HI,  32'hDEADBEEF,  8'd1,   5'd1,  1'b0, 1'b1, '{STAT_DONE, 32'h0, 5'd6}},
        // 6 5 min max -1 0: take min from the middle
        '{CMD_DEL_POS,   32'h0,         8'd3,   5'd1,  1'b0, 1'b1, '{STAT_DONE, 32'h80000000, 5'd5}},
        '{CMD_DEL_BACK,  32'h0,         8'd0,   5'd1,  1'b0, 1'b1, '{STAT_DONE, 32'h0, 5'd4}},
        '{CMD_DEL_BACK,  32'h0,         8'd0,   5'd1,  1'b0, 1'b1, '{STAT_DONE, 32'hFFFFFFFF, 5'd3}},
        '{CMD_DEL_FRONT, 32'h0,         8'd0,   5'd1,  1'b0, 1'b1, '{STAT_DONE, 32'd6, 5'd2}},
        // fill to the top with random values, then hit the full list
        '{CMD_ADD_BACK,  32'h0,         8'd0,   5'd14, 1'b1, 1'b0, '0},
        '{CMD_ADD_FRONT, 32'd1,         8'd0,   5'd1,  1'b0, 1'b1, '{STAT_FULL, 32'h0, 5'd16}},
        '{CMD_ADD_POS,   32'd2,         8'd255, 5'd1,  1'b0, 1'b1, '{STAT_FULL, 32'h0, 5'd16}},
        '{CMD_DEL_POS,   32'h0,         8'd17,  5'd1,  1'b0, 1'b1, '{STAT_NONE, 32'h0, 5'd16}},
        '{CMD_DEL_POS,   32'h0,         8'd16,  5'd1,  1'b0, 1'b0, '0}
    };

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;   // cmd[2:0], value[34:3], pos[42:35], zero fill
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;         // status[1:0], removed_value[33:2], count[38:34]

    // mirror of the list held in the block
    logic [VALUE_W-1:0] list_mirror [LIST_DEPTH];
    int                 list_len = 0;

    list_result_t pending_results [$];

    // typed result for the command currently offered, if the row has one
    logic         row_known  = 1'b0;
    list_result_t row_expect = '0;

    // no idling on either side while set
    bit steady = 1'b0;

    int mismatches  = 0;
    int cycle_count = 0;
    int n_ins = 0, n_del = 0, n_spare = 0, n_full = 0, n_none = 0, peak_len = 0;

    ordered_list_insert_delete #(.LIST_DEPTH(LIST_DEPTH)) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Apply one command to the mirror and return the result it must yield.
    function automatic list_result_t apply_list_cmd(logic [CMD_W-1:0] op,
                                                    logic [VALUE_W-1:0] val,
                                                    logic [POS_W-1:0] pos);
        list_result_t r;
        int slot;
        int at;
        int k;
        r = '0;
        slot = (pos <= 1) ? 0 : int'(pos) - 1;
        case (op)
            CMD_ADD_FRONT, CMD_ADD_BACK, CMD_ADD_POS: begin
                if (list_len >= LIST_DEPTH) begin
                    r.status = STAT_FULL;
                end else begin
                    if (op == CMD_ADD_FRONT) at = 0;
                    else if (op == CMD_ADD_BACK) at = list_len;
                    else at = (slot > list_len) ? list_len : slot;
                    for (k = list_len; k > at; k--) list_mirror[k] = list_mirror[k-1];
                    list_mirror[at] = val;
                    list_len++;
                end
            end
            CMD_DEL_FRONT, CMD_DEL_BACK, CMD_DEL_POS: begin
                if (op == CMD_DEL_FRONT) at = 0;
                else if (op == CMD_DEL_BACK) at = list_len - 1;
                else at = slot;
                // empty list or a place past the back: nothing to take
                if (list_len == 0 || at >= list_len) begin
                    r.status = STAT_NONE;
                end else begin
                    r.removed = list_mirror[at];
                    for (k = at; k + 1 < list_len; k++) list_mirror[k] = list_mirror[k+1];
                    list_len--;
                end
            end
            default: ;
        endcase
        r.count = list_len[4:0];
        return r;
    endfunction

    // Offer one command transaction and hold it until the block takes it.
    // Entered and left at a falling edge.
    task automatic send_cmd(input logic [CMD_W-1:0] op, input logic [VALUE_W-1:0] val,
                            input logic [POS_W-1:0] pos, input logic known,
                            input list_result_t want);
        while (!steady && $urandom_range(0, 99) < 28) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid   <= 1'b1;
        s_tdata    <= {5'b0, pos, val, op};
        row_known  <= known;
        row_expect <= want;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // result side back-pressure
    always @(negedge aclk) begin
        m_tready <= steady || ($urandom_range(0, 99) >= 28);
    end

    // Scoreboard: results are checked before this edge's command is
    // predicted; a result never leaves in the cycle its command enters.
    always @(posedge aclk) begin
        list_result_t got;
        list_result_t want;
        list_result_t predicted;
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("FAILED: results differ");
            $finish;
        end
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = {m_tdata[1:0], m_tdata[33:2], m_tdata[38:34]};
                if (pending_results.size() == 0) begin
                    $error("result transaction with no command outstanding");
                    mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        mismatches++;
                    end
                    if (got.removed !== want.removed) begin
                        $error("removed_value: expected %0d, got %0d",
                               $signed(want.removed), $signed(got.removed));
                        mismatches++;
                    end
                    if (got.count !== want.count) begin
                        $error("count: expected %0d, got %0d", want.count, got.count);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                predicted = apply_list_cmd(s_tdata[2:0], s_tdata[34:3], s_tdata[42:35]);
                // a typed row result takes the place of the prediction
                pending_results.push_back(row_known ? row_expect : predicted);
                case (s_tdata[2:0])
                    CMD_ADD_FRONT, CMD_ADD_BACK, CMD_ADD_POS: n_ins++;
                    CMD_DEL_FRONT, CMD_DEL_BACK, CMD_DEL_POS: n_del++;
                    default: n_spare++;
                endcase
                if (predicted.status == STAT_FULL) n_full++;
                if (predicted.status == STAT_NONE) n_none++;
                if (list_len > peak_len) peak_len = list_len;
            end
        end
    end

    initial begin
        logic [CMD_W-1:0]   op;
        logic [VALUE_W-1:0] val;
        logic [POS_W-1:0]   pos;
        int                 ins_bias;
        int                 pick;
        int                 n;
        int                 i;
        int                 r;
        ins_bias = 50;
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed rows
        for (i = 0; i < DIR_ROWS; i++) begin
            for (r = 0; r < DIR_TABLE[i].reps; r++) begin
                val = DIR_TABLE[i].fresh ? $urandom : DIR_TABLE[i].value;
                send_cmd(DIR_TABLE[i].op, val, DIR_TABLE[i].pos, DIR_TABLE[i].known,
                         DIR_TABLE[i].want);
            end
        end

        // Random commands. The insert share moves every hundred commands so the
        // list swings between empty and full; one stretch runs with no idling.
        for (n = 0; n < RAND_CMDS; n++) begin
            if (n % 100 == 0) begin
                case ($urandom_range(0, 3))
                    0: ins_bias = 20;
                    1: ins_bias = 50;
                    2: ins_bias = 75;
                    default: ins_bias = 92;
                endcase
            end
            steady = (n >= 500 && n < 700);
            pick = $urandom_range(0, 99);
            if (pick < 3) op = $urandom_range(0, 1) ? CMD_SPARE_HI : CMD_SPARE_LO;
            else if (pick < ins_bias) op = ADD_CODES[$urandom_range(0, 2)];
            else op = DEL_CODES[$urandom_range(0, 2)];
            // positions mostly near the live range, some anywhere
            if ($urandom_range(0, 9) < 7) pos = POS_W'($urandom_range(0, list_len + 2));
            else pos = POS_W'($urandom_range(0, 255));
            if ($urandom_range(0, 9) == 0) val = $urandom_range(0, 1) ? 32'h80000000 : 32'h7FFFFFFF;
            else val = $urandom;
            send_cmd(op, val, pos, 1'b0, '0);
        end
        s_tvalid <= 1'b0;
        steady = 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("ran %0d inserts, %0d deletes, %0d unused codes; peak length %0d",
                 n_ins, n_del, n_spare, peak_len);
        $display("rejected %0d inserts on a full list, %0d deletes with nothing there",
                 n_full, n_none);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

`default_nettype wire
